### rtl/number_string_tokenizer_top_defines.svh
// Assertion macros for the number string tokenizer checker.
`ifndef NUMBER_STRING_TOKENIZER_TOP_DEFINES_SVH
`define NUMBER_STRING_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nst_pkg.sv
// Types and codes shared by the number string tokenizer files.
package nst_pkg;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_INT  = 3'd1;
  localparam logic [2:0] MODE_DOT  = 3'd2;
  localparam logic [2:0] MODE_FRAC = 3'd3;
  localparam logic [2:0] MODE_STR  = 3'd4;
  localparam logic [2:0] MODE_ESC  = 3'd5;

  localparam logic [1:0] EV_CONTENT = 2'd0;
  localparam logic [1:0] EV_DONE    = 2'd1;
  localparam logic [1:0] EV_ERROR   = 2'd2;

  localparam logic [1:0] TOK_END     = 2'd0;
  localparam logic [1:0] TOK_NEWLINE = 2'd1;
  localparam logic [1:0] TOK_STRING  = 2'd2;
  localparam logic [1:0] TOK_NUMBER  = 2'd3;

  localparam logic [1:0] ER_UNTERMINATED = 2'd0;
  localparam logic [1:0] ER_DIGIT        = 2'd1;
  localparam logic [1:0] ER_UNRECOGNIZED = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [1:0] token_kind;
    logic [7:0] content;
    logic [1:0] error_kind;
    logic       last;
  } nst_res_t;

endpackage

### rtl/nst_if.sv
// Byte input and result output channel interfaces.
interface nst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface nst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [1:0] token_kind;
  logic [7:0] content;
  logic [1:0] error_kind;
  logic       last;

  modport source (
    output valid, output event_kind, output token_kind, output content,
    output error_kind, output last, input ready
  );
  modport sink (
    input valid, input event_kind, input token_kind, input content,
    input error_kind, input last, output ready
  );
endinterface

### rtl/number_string_tokenizer_top.sv
// Streaming tokenizer for numbers, strings and newlines, one byte per item.
//
//   channel  dir  payload                                         per item
//   in_i     in   char_byte, end_of_text                          one byte
//   out_o    out  event_kind, token_kind, content, error_kind,    0 to 2 results
//                 last
//
// One byte enters per cycle while the result buffer has room; it is lexed from the
// input register and its results land in a two-entry result buffer.
// After a byte with two results, the next byte waits in the input register
// while the buffer drains, so every result leaves through out_o on its own.
// Reset clears the lexer mode, the quote kind, the input valid flag and the result count.
// A stall on out_o backs up into in_ready once the input register is full.
module number_string_tokenizer_top (
  input logic       clk_i,
  input logic       rst_ni,
  nst_in_if.sink    in_i,
  nst_out_if.source out_o
);

  logic             in_vld_q;
  logic [7:0]       byte_q;
  logic             eot_q;
  logic [2:0]       mode_q, mode_d;
  logic             qd_q, qd_d;
  logic [1:0]       cnt_q, cnt_d;
  nst_pkg::nst_res_t slot0_q, slot0_d, slot1_q, slot1_d;

  logic             pop, take, in_fire;
  logic             eot;
  logic [7:0]       c;
  logic [7:0]       quote_ch;
  logic             is_digit;
  logic             idle_has;
  logic [2:0]       idle_mode;
  logic             idle_qd;
  nst_pkg::nst_res_t idle_res;
  nst_pkg::nst_res_t r0, r1;
  logic [1:0]       n;
  logic [7:0]       esc_ch;
  logic             esc_keep;

  function automatic nst_pkg::nst_res_t mk_res(input logic [1:0] ev, input logic [1:0] tk,
                                               input logic [7:0] ch, input logic [1:0] ek);
    nst_pkg::nst_res_t r;
    r.event_kind = ev;
    r.token_kind = tk;
    r.content    = ch;
    r.error_kind = ek;
    r.last       = 1'b0;
    return r;
  endfunction

  assign pop     = (cnt_q != 2'd0) && out_o.ready;
  assign take    = in_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_i.ready = !in_vld_q || take;
  assign in_fire = in_i.valid && in_i.ready;

  assign eot      = eot_q || (byte_q == nst_pkg::CH_NUL);
  assign c        = eot ? nst_pkg::CH_NUL : byte_q;
  assign quote_ch = qd_q ? nst_pkg::CH_DQUOTE : nst_pkg::CH_SQUOTE;
  assign is_digit = c inside {[nst_pkg::CH_ZERO:nst_pkg::CH_NINE]};

  always_comb begin
    idle_mode = nst_pkg::MODE_IDLE;
    idle_qd   = qd_q;
    idle_has  = 1'b1;
    idle_res  = mk_res(nst_pkg::EV_ERROR, nst_pkg::TOK_END, c, nst_pkg::ER_UNRECOGNIZED);
    if (eot) begin
      idle_res = mk_res(nst_pkg::EV_DONE, nst_pkg::TOK_END, 8'd0, 2'd0);
    end else if (c inside {nst_pkg::CH_LF, nst_pkg::CH_CR}) begin
      idle_res = mk_res(nst_pkg::EV_DONE, nst_pkg::TOK_NEWLINE, 8'd0, 2'd0);
    end else if (c inside {nst_pkg::CH_SQUOTE, nst_pkg::CH_DQUOTE}) begin
      idle_qd   = (c == nst_pkg::CH_DQUOTE);
      idle_mode = nst_pkg::MODE_STR;
      idle_has  = 1'b0;
    end else if (c inside {nst_pkg::CH_SPACE, nst_pkg::CH_TAB, nst_pkg::CH_VT,
                           nst_pkg::CH_FF}) begin
      idle_has = 1'b0;
    end else if (is_digit) begin
      idle_mode = nst_pkg::MODE_INT;
      idle_res  = mk_res(nst_pkg::EV_CONTENT, nst_pkg::TOK_NUMBER, c, 2'd0);
    end
  end

  always_comb begin
    esc_keep = 1'b1;
    case (c)
      8'h6E:             esc_ch = nst_pkg::CH_LF;
      8'h72:             esc_ch = nst_pkg::CH_CR;
      8'h61:             esc_ch = 8'h07;
      8'h62:             esc_ch = 8'h08;
      8'h66:             esc_ch = nst_pkg::CH_FF;
      8'h76:             esc_ch = nst_pkg::CH_VT;
      nst_pkg::CH_BSLASH: esc_ch = nst_pkg::CH_BSLASH;
      nst_pkg::CH_DQUOTE: esc_ch = nst_pkg::CH_DQUOTE;
      nst_pkg::CH_SQUOTE: esc_ch = nst_pkg::CH_SQUOTE;
      8'h3F:             esc_ch = 8'h3F;
      nst_pkg::CH_LF,
      nst_pkg::CH_CR:    esc_ch = nst_pkg::CH_LF;
      default: begin
        esc_ch   = 8'd0;
        esc_keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    qd_d   = qd_q;
    n      = 2'd0;
    r0     = idle_res;
    r1     = idle_res;
    case (mode_q)
      nst_pkg::MODE_INT, nst_pkg::MODE_FRAC: begin
        if (is_digit) begin
          r0 = mk_res(nst_pkg::EV_CONTENT, nst_pkg::TOK_NUMBER, c, 2'd0);
          n  = 2'd1;
        end else if (mode_q == nst_pkg::MODE_INT && c == nst_pkg::CH_DOT) begin
          mode_d = nst_pkg::MODE_DOT;
          r0     = mk_res(nst_pkg::EV_CONTENT, nst_pkg::TOK_NUMBER, c, 2'd0);
          n      = 2'd1;
        end else begin
          r0     = mk_res(nst_pkg::EV_DONE, nst_pkg::TOK_NUMBER, 8'd0, 2'd0);
          n      = {idle_has, !idle_has};
          mode_d = idle_mode;
          qd_d   = idle_qd;
        end
      end
      nst_pkg::MODE_DOT: begin
        if (is_digit) begin
          mode_d = nst_pkg::MODE_FRAC;
          r0     = mk_res(nst_pkg::EV_CONTENT, nst_pkg::TOK_NUMBER, c, 2'd0);
          n      = 2'd1;
        end else begin
          r0     = mk_res(nst_pkg::EV_ERROR, nst_pkg::TOK_END, c, nst_pkg::ER_DIGIT);
          n      = {idle_has, !idle_has};
          mode_d = idle_mode;
          qd_d   = idle_qd;
        end
      end
      nst_pkg::MODE_STR: begin
        if (eot || (c inside {nst_pkg::CH_LF, nst_pkg::CH_CR})) begin
          r0     = mk_res(nst_pkg::EV_ERROR, nst_pkg::TOK_END, c, nst_pkg::ER_UNTERMINATED);
          n      = {idle_has, !idle_has};
          mode_d = idle_mode;
          qd_d   = idle_qd;
        end else if (c == quote_ch) begin
          mode_d = nst_pkg::MODE_IDLE;
          r0     = mk_res(nst_pkg::EV_DONE, nst_pkg::TOK_STRING, 8'd0, 2'd0);
          n      = 2'd1;
        end else if (c == nst_pkg::CH_BSLASH) begin
          mode_d = nst_pkg::MODE_ESC;
        end else begin
          r0 = mk_res(nst_pkg::EV_CONTENT, nst_pkg::TOK_STRING, c, 2'd0);
          n  = 2'd1;
        end
      end
      nst_pkg::MODE_ESC: begin
        if (eot) begin
          r0     = mk_res(nst_pkg::EV_ERROR, nst_pkg::TOK_END, 8'd0,
                          nst_pkg::ER_UNTERMINATED);
          n      = {idle_has, !idle_has};
          mode_d = idle_mode;
          qd_d   = idle_qd;
        end else begin
          mode_d = nst_pkg::MODE_STR;
          r0     = mk_res(nst_pkg::EV_CONTENT, nst_pkg::TOK_STRING, esc_ch, 2'd0);
          n      = {1'b0, esc_keep};
        end
      end
      default: begin
        r0     = idle_res;
        n      = {1'b0, idle_has};
        mode_d = idle_mode;
        qd_d   = idle_qd;
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (take) begin
      cnt_d   = n;
      slot0_d = r0;
      slot1_d = r1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= nst_pkg::MODE_IDLE;
      qd_q     <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (take) begin
        in_vld_q <= 1'b0;
      end
      if (take) begin
        mode_q <= mode_d;
        qd_q   <= qd_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_i.char_byte;
      eot_q  <= in_i.end_of_text;
    end
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.event_kind = slot0_q.event_kind;
  assign out_o.token_kind = slot0_q.token_kind;
  assign out_o.content    = slot0_q.content;
  assign out_o.error_kind = slot0_q.error_kind;
  assign out_o.last       = slot0_q.last;

endmodule

### rtl/nst_chk.sv
// Port-level checker for the number string tokenizer, bound to the top level.
`include "number_string_tokenizer_top_defines.svh"

module nst_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] event_kind_i,
  input logic [1:0] token_kind_i,
  input logic [7:0] content_i,
  input logic [1:0] error_kind_i,
  input logic       last_i
);

  logic [14:0] payload;
  logic        content_item;
  logic        content_ok;
  logic        done_item;
  logic        done_ok;
  assign payload = {event_kind_i, token_kind_i, content_i, error_kind_i, last_i};
  assign content_item = out_valid_i && event_kind_i == nst_pkg::EV_CONTENT;
  assign content_ok = (token_kind_i == nst_pkg::TOK_STRING ||
                       token_kind_i == nst_pkg::TOK_NUMBER) && error_kind_i == 2'd0;
  assign done_item = out_valid_i && event_kind_i == nst_pkg::EV_DONE;
  assign done_ok = content_i == 8'd0 && error_kind_i == 2'd0;

  `NST_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(payload), "result changed while stalled")
  `NST_ASSERT_NEXT(a_second_follows, clk_i, rst_ni, out_valid_i && out_ready_i && !last_i, out_valid_i, "second result of an item missing")
  `NST_ASSERT_NOW(a_content_kind, clk_i, rst_ni, content_item, content_ok, "content item with bad token kind")
  `NST_ASSERT_NOW(a_done_clean, clk_i, rst_ni, done_item, done_ok, "token complete item malformed")

endmodule

bind number_string_tokenizer_top nst_chk u_nst_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_kind_i (out_o.event_kind),
  .token_kind_i (out_o.token_kind),
  .content_i    (out_o.content),
  .error_kind_i (out_o.error_kind),
  .last_i       (out_o.last)
);
